// ----- src/lwf_pkg.sv -----
// Shared types, constants and codes of the wall-following PD steering block.
package lwf_pkg;

	// Scan geometry
	localparam int SCAN_SIZE = 720;
	localparam int CNT_W = $clog2(SCAN_SIZE);
	localparam int IDX_W = CNT_W + 1;
	localparam int PA_W = IDX_W + 16;

	// Half-scan windows per followed side, upper bound exclusive
	localparam int WIN_LO_NEG = 0;
	localparam int WIN_HI_NEG = SCAN_SIZE * 2 / 4;
	localparam int WIN_LO_ZERO = SCAN_SIZE / 4;
	localparam int WIN_HI_ZERO = SCAN_SIZE * 3 / 4;
	localparam int WIN_LO_POS = SCAN_SIZE * 2 / 4;
	localparam int WIN_HI_POS = SCAN_SIZE * 4 / 4;
	localparam int FRONT_IDX = SCAN_SIZE / 2;

	// Fixed-point constants
	localparam int HALF_PI_Q12 = 6434;
	localparam int ANGLE_LIMIT_Q12 = 7168;
	localparam int SPEED_STEP_Q8 = 128;
	localparam int DRIVE_RESET = 512;

	// floor(y / 10) = (y * DIV10_MUL) >> DIV10_SHIFT, exact for y < 2^22
	localparam int DIV10_MUL = 838861;
	localparam int DIV10_SHIFT = 23;
	localparam int DIV10_BIAS = 10 * 65536;

	// Input action codes
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_FASTER = 2'd1;
	localparam logic [1:0] ACT_SLOWER = 2'd2;
	localparam logic [1:0] ACT_REPEAT = 2'd3;

	// Register map
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_WALL_DISTANCE = 3'd0;
	localparam logic [2:0] REG_FOLLOW_SIDE = 3'd1;
	localparam logic [2:0] REG_P_GAIN = 3'd2;
	localparam logic [2:0] REG_D_GAIN = 3'd3;
	localparam logic [2:0] REG_ANGLE_GAIN = 3'd4;
	localparam logic [2:0] REG_ANGLE_STEP = 3'd5;

	typedef struct packed {
		logic [15:0] wall_distance;
		logic signed [1:0] follow_side;
		logic signed [15:0] p_gain;
		logic signed [15:0] d_gain;
		logic signed [15:0] angle_gain;
		logic signed [15:0] angle_step;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [15:0] range_sample;
	} item_t;

	typedef struct packed {
		logic signed [15:0] angular_rate;
		logic signed [15:0] linear_speed;
		logic [15:0] nearest_distance;
		logic signed [15:0] nearest_angle;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic step1;
		logic step2;
		logic step3;
		logic step4;
		logic step5;
		logic load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_end;
	} stat_t;

endpackage

// ----- src/lwf_regs.sv -----
// Configuration register file with APB-style access.
module lwf_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lwf_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output lwf_pkg::cfg_t                cfg
);

	lwf_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wall_distance <= 16'd256;
			cfg_q.follow_side   <= 2'sb01;
			cfg_q.p_gain        <= 16'sd256;
			cfg_q.d_gain        <= 16'sd0;
			cfg_q.angle_gain    <= 16'sd0;
			cfg_q.angle_step    <= 16'sd286;
		end else if (wr_en) begin
			unique case (reg_idx)
				lwf_pkg::REG_WALL_DISTANCE: cfg_q.wall_distance <= pwdata[15:0];
				lwf_pkg::REG_FOLLOW_SIDE:   cfg_q.follow_side   <= pwdata[1:0];
				lwf_pkg::REG_P_GAIN:        cfg_q.p_gain        <= pwdata[15:0];
				lwf_pkg::REG_D_GAIN:        cfg_q.d_gain        <= pwdata[15:0];
				lwf_pkg::REG_ANGLE_GAIN:    cfg_q.angle_gain    <= pwdata[15:0];
				lwf_pkg::REG_ANGLE_STEP:    cfg_q.angle_step    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back, signed fields sign-extended
	always_comb begin
		unique case (reg_idx)
			lwf_pkg::REG_WALL_DISTANCE: prdata = {16'd0, cfg_q.wall_distance};
			lwf_pkg::REG_FOLLOW_SIDE:   prdata = {{30{cfg_q.follow_side[1]}}, cfg_q.follow_side};
			lwf_pkg::REG_P_GAIN:        prdata = {{16{cfg_q.p_gain[15]}}, cfg_q.p_gain};
			lwf_pkg::REG_D_GAIN:        prdata = {{16{cfg_q.d_gain[15]}}, cfg_q.d_gain};
			lwf_pkg::REG_ANGLE_GAIN:    prdata = {{16{cfg_q.angle_gain[15]}}, cfg_q.angle_gain};
			lwf_pkg::REG_ANGLE_STEP:    prdata = {{16{cfg_q.angle_step[15]}}, cfg_q.angle_step};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

// ----- src/lwf_dp.sv -----
// Datapath: scan tracking, speed keys and the stepped end-of-scan computation.
module lwf_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  lwf_pkg::cfg_t    cfg,
	input  lwf_pkg::item_t   item,
	input  lwf_pkg::cmd_t    cmd,
	output lwf_pkg::stat_t   stat,
	output lwf_pkg::result_t result
);

	localparam int CW = lwf_pkg::CNT_W;
	localparam int IW = lwf_pkg::IDX_W;
	localparam int PW = lwf_pkg::PA_W;

	// scan state
	logic [CW-1:0]       cnt_q;
	logic [15:0]         near_val_q;
	logic [CW-1:0]       near_pos_q;
	logic [15:0]         front_q;
	logic signed [16:0]  prev_err_q;
	logic signed [15:0]  drive_q;
	logic signed [8:0]   step_q;

	// end-of-scan intermediates
	logic signed [PW-1:0] prod_a_q;
	logic signed [16:0]   err_q;
	logic signed [17:0]   diff_q;
	logic signed [15:0]   ang12_q;
	logic signed [32:0]   pe_q;
	logic signed [33:0]   dd_q;
	logic signed [16:0]   dev_q;
	logic signed [32:0]   ad_q;
	logic signed [34:0]   pd_q;
	logic signed [39:0]   total_q;
	logic signed [15:0]   fifth_q;
	lwf_pkg::result_t     res_q;

	logic                 side_neg, side_pos;
	logic [IW-1:0]        idx, win_lo, win_hi;
	logic                 cnt_end, take_sample, take_key;
	logic signed [8:0]    step_new;
	logic signed [16:0]   drive_sum;
	logic signed [15:0]   drive_new;
	logic signed [IW-1:0] dpos;
	logic signed [16:0]   err_c;
	logic signed [17:0]   diff_c;
	logic signed [PW:0]   ta_sum, ta;
	logic signed [15:0]   ang_sat;
	logic signed [16:0]   ang17, dev_c;
	logic signed [39:0]   spd;
	logic signed [17:0]   x18;
	logic [19:0]          y20;
	logic [39:0]          q_prod;
	logic [16:0]          q17, q_unbias;
	logic signed [40:0]   tr_sum, tr;
	logic signed [15:0]   ang_rate;
	logic signed [16:0]   half_sum;
	logic signed [15:0]   lin;

	// side decode and window bounds
	always_comb begin
		side_neg = cfg.follow_side[1];
		side_pos = (cfg.follow_side == 2'sb01);
		idx      = {1'b0, cnt_q};
		priority if (side_neg) begin
			win_lo = IW'(lwf_pkg::WIN_LO_NEG);
			win_hi = IW'(lwf_pkg::WIN_HI_NEG);
		end else if (side_pos) begin
			win_lo = IW'(lwf_pkg::WIN_LO_POS);
			win_hi = IW'(lwf_pkg::WIN_HI_POS);
		end else begin
			win_lo = IW'(lwf_pkg::WIN_LO_ZERO);
			win_hi = IW'(lwf_pkg::WIN_HI_ZERO);
		end
		cnt_end = (idx + IW'(1)) >= IW'(lwf_pkg::SCAN_SIZE);
	end

	assign stat.scan_end = (item.action == lwf_pkg::ACT_SAMPLE) && cnt_end;
	assign take_sample   = cmd.take && (item.action == lwf_pkg::ACT_SAMPLE);
	assign take_key      = cmd.take && (item.action != lwf_pkg::ACT_SAMPLE);

	// speed key: pick the step, add with saturation
	always_comb begin
		unique case (item.action)
			lwf_pkg::ACT_FASTER: step_new = 9'(lwf_pkg::SPEED_STEP_Q8);
			lwf_pkg::ACT_SLOWER: step_new = -9'(lwf_pkg::SPEED_STEP_Q8);
			default:             step_new = step_q;
		endcase
		drive_sum = {drive_q[15], drive_q} + {{8{step_new[8]}}, step_new};
		if (drive_sum[16] == drive_sum[15])
			drive_new = drive_sum[15:0];
		else
			drive_new = drive_sum[16] ? 16'sh8000 : 16'sh7FFF;
	end

	// per-item state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			near_val_q <= '0;
			near_pos_q <= '0;
			front_q    <= '0;
			prev_err_q <= '0;
			drive_q    <= 16'(lwf_pkg::DRIVE_RESET);
			step_q     <= '0;
		end else begin
			if (take_sample) begin
				if (idx == win_lo) begin
					near_val_q <= item.range_sample;
					near_pos_q <= cnt_q;
				end else if (idx > win_lo && idx < win_hi && item.range_sample != 16'd0 &&
				             item.range_sample < near_val_q) begin
					near_val_q <= item.range_sample;
					near_pos_q <= cnt_q;
				end
				if (idx == IW'(lwf_pkg::FRONT_IDX))
					front_q <= item.range_sample;
				cnt_q <= cnt_end ? '0 : cnt_q + CW'(1);
			end
			if (take_key) begin
				step_q  <= step_new;
				drive_q <= drive_new;
			end
			if (cmd.step1)
				prev_err_q <= err_c;
		end
	end

	// step 1 terms: angle product and wall error
	assign dpos   = $signed({1'b0, near_pos_q}) - $signed(IW'(lwf_pkg::FRONT_IDX));
	assign err_c  = $signed({1'b0, near_val_q}) - $signed({1'b0, cfg.wall_distance});
	assign diff_c = $signed({err_c[16], err_c}) - $signed({prev_err_q[16], prev_err_q});

	// step 2 terms: round angle to Q4.12 and saturate
	always_comb begin
		ta_sum = $signed({prod_a_q[PW-1], prod_a_q}) + $signed((PW+1)'(2));
		ta     = ta_sum >>> 2;
		if ((&ta[PW:15]) || !(|ta[PW:15]))
			ang_sat = ta[15:0];
		else
			ang_sat = ta[PW] ? 16'sh8000 : 16'sh7FFF;
	end

	// step 3 terms: angle deviation from perpendicular
	always_comb begin
		ang17 = {ang12_q[15], ang12_q};
		priority if (side_pos)
			dev_c = ang17 - $signed(17'(lwf_pkg::HALF_PI_Q12));
		else if (side_neg)
			dev_c = ang17 + $signed(17'(lwf_pkg::HALF_PI_Q12));
		else
			dev_c = ang17;
	end

	// step 5 terms: side-signed PD sum and the fifth of the drive speed
	always_comb begin
		priority if (side_pos)
			spd = {pd_q[34], pd_q, 4'b0000};
		else if (side_neg)
			spd = -$signed({pd_q[34], pd_q, 4'b0000});
		else
			spd = '0;
		x18      = $signed({drive_q[15], drive_q, 1'b0}) + 18'sd5;
		y20      = 20'({{2{x18[17]}}, x18}) + 20'(lwf_pkg::DIV10_BIAS);
		q_prod   = y20 * 20'(lwf_pkg::DIV10_MUL);
		q17      = q_prod[lwf_pkg::DIV10_SHIFT+16:lwf_pkg::DIV10_SHIFT];
		q_unbias = q17 - 17'h10000;
	end

	// end-of-scan steps, one multiplier per step
	always_ff @(posedge clk) begin
		if (cmd.step1) begin
			prod_a_q <= dpos * $signed(cfg.angle_step);
			err_q    <= err_c;
			diff_q   <= diff_c;
		end
		if (cmd.step2) begin
			ang12_q <= ang_sat;
			pe_q    <= $signed(cfg.p_gain) * err_q;
		end
		if (cmd.step3) begin
			dd_q  <= $signed(cfg.d_gain) * diff_q;
			dev_q <= dev_c;
		end
		if (cmd.step4) begin
			ad_q <= $signed(cfg.angle_gain) * dev_q;
			pd_q <= $signed({{2{pe_q[32]}}, pe_q}) + $signed({dd_q[33], dd_q});
		end
		if (cmd.step5) begin
			total_q <= spd + $signed({{7{ad_q[32]}}, ad_q});
			fifth_q <= q_unbias[15:0];
		end
		if (cmd.load) begin
			res_q.angular_rate     <= ang_rate;
			res_q.linear_speed     <= lin;
			res_q.nearest_distance <= near_val_q;
			res_q.nearest_angle    <= ang12_q;
		end
	end

	// final: round steering to Q8.8, choose forward speed
	always_comb begin
		tr_sum = $signed({total_q[39], total_q}) + 41'sd2048;
		tr     = tr_sum >>> 12;
		if ((&tr[40:15]) || !(|tr[40:15]))
			ang_rate = tr[15:0];
		else
			ang_rate = tr[40] ? 16'sh8000 : 16'sh7FFF;
		half_sum = $signed({drive_q[15], drive_q}) + 17'sd1;
		priority if (front_q < cfg.wall_distance)
			lin = '0;
		else if ({1'b0, front_q} < {cfg.wall_distance, 1'b0})
			lin = half_sum[16:1];
		else if (ang12_q > $signed(16'(lwf_pkg::ANGLE_LIMIT_Q12)) ||
		         ang12_q < -$signed(16'(lwf_pkg::ANGLE_LIMIT_Q12)))
			lin = fifth_q;
		else
			lin = drive_q;
	end

	assign result = res_q;

endmodule

// ----- src/lwf_ctrl.sv -----
// Controller: input acceptance, end-of-scan step sequence and result valid.
module lwf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	output logic           result_valid,
	input  logic           result_stall,
	input  lwf_pkg::stat_t stat,
	output lwf_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_C1   = 3'd1;
	localparam logic [2:0] S_C2   = 3'd2;
	localparam logic [2:0] S_C3   = 3'd3;
	localparam logic [2:0] S_C4   = 3'd4;
	localparam logic [2:0] S_C5   = 3'd5;
	localparam logic [2:0] S_C6   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       res_valid_q;
	logic       take;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign take         = item_valid && (state_q == S_IDLE);

	// commands
	always_comb begin
		cmd.take  = take;
		cmd.step1 = (state_q == S_C1);
		cmd.step2 = (state_q == S_C2);
		cmd.step3 = (state_q == S_C3);
		cmd.step4 = (state_q == S_C4);
		cmd.step5 = (state_q == S_C5);
		cmd.load  = (state_q == S_C6) && (!res_valid_q || !result_stall);
	end

	// next state
	always_comb begin
		unique case (state_q)
			S_IDLE:  state_d = (take && stat.scan_end) ? S_C1 : S_IDLE;
			S_C1:    state_d = S_C2;
			S_C2:    state_d = S_C3;
			S_C3:    state_d = S_C4;
			S_C4:    state_d = S_C5;
			S_C5:    state_d = S_C6;
			S_C6:    state_d = cmd.load ? S_IDLE : S_C6;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	// sequence only starts on the last sample of a scan
	ap_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_C1) |-> $past(take && stat.scan_end))
		else $error("step sequence started without a scan end");

	// a new result appears only out of the final step
	ap_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_C6))
		else $error("result valid rose outside the final step");

	// a held result is never overwritten
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_C6 && res_valid_q && result_stall) |=> (state_q == S_C6))
		else $error("final step left while result was held");

endmodule

// ----- src/lidar_wall_follow_pd_steering.sv -----
// Top level of the wall-following PD steering block.
// Range samples and speed keys are taken one per cycle while no scan result is being formed or waiting to be loaded.
// The last sample of a scan starts a six-step sequence (one multiplier per computing step, none
// in the final load step); input stalls while it runs, and the result item is valid once the
// final step loads it. Asynchronous active-low reset restores the configuration registers,
// scan state and controller at once; end-of-scan intermediates and the result are not reset.
module lidar_wall_follow_pd_steering (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lwf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  lwf_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output lwf_pkg::result_t            result
);

	lwf_pkg::cfg_t  cfg;
	lwf_pkg::cmd_t  cmd;
	lwf_pkg::stat_t stat;

	lwf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lwf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	lwf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule
